// File: rtl/core/gpio_port_bias_direction_shadow_core_macros.svh
// Assertion macros used by the checker of the GPIO port shadow core.
// Depends on nothing; included by the checker file.
`ifndef GPIO_PORT_BIAS_DIRECTION_SHADOW_CORE_MACROS_SVH
`define GPIO_PORT_BIAS_DIRECTION_SHADOW_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GPBDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GPBDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gpbds_pkg.sv
// Types and constants of the GPIO port shadow core.
// No dependencies; imported by every other file of the block but the macro header.
package gpbds_pkg;

    localparam int NUM_PORTS      = 16;
    localparam int LINES_PER_PORT = 8;

    localparam int MASK_W    = 8;
    localparam int CMD_W     = 4;
    localparam int PIDX_W    = 4;
    localparam int LINE_W    = 3;
    localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PEXT_W    = (PORT_AW > PIDX_W) ? PORT_AW : PIDX_W;

    localparam logic [MASK_W-1:0] LINE_FIELD_MASK =
        MASK_W'((9'd1 << LINES_PER_PORT) - 9'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 4'd0,
        CMD_INPUT    = 4'd1,
        CMD_OUTPUT   = 4'd2,
        CMD_SETVAL   = 4'd3,
        CMD_BIAS_OFF = 4'd4,
        CMD_HIGHZ    = 4'd5,
        CMD_PULL_DEF = 4'd6,
        CMD_PULL_UP  = 4'd7,
        CMD_INVAL    = 4'd8
    } t_cmd;

    typedef enum logic {
        ST_OK          = 1'b0,
        ST_UNSUPPORTED = 1'b1
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PIDX_W-1:0] port_index;
        logic [LINE_W-1:0] line;
        logic              level;
        logic [MASK_W-1:0] value_mask;
        logic [MASK_W-1:0] value_bits;
        logic              arg_nonzero;
        logic [MASK_W-1:0] readback_port;
        logic [MASK_W-1:0] readback_ddr;
    } t_req;

    typedef struct packed {
        logic              write_strobe;
        logic [MASK_W-1:0] port_reg;
        logic [MASK_W-1:0] ddr_reg;
        logic [MASK_W-1:0] direction_bits;
        logic              status;
    } t_rsp;

    // One memory word holds the whole shadow state of a port.
    typedef struct packed {
        logic [MASK_W-1:0]   dir;
        logic [MASK_W-1:0]   outv;
        logic [MASK_W-1:0]   bias_on;
        logic [MASK_W-1:0]   bias_hard;
        logic [2*MASK_W-1:0] last_pair;
        logic                last_valid;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_entry wdata;
        t_rsp   rsp;
    } t_upd;

endpackage

// File: rtl/core/gpbds_if.sv
// Request and response channel interfaces of the GPIO port shadow core.
// Depends on gpbds_pkg for the payload types.
interface gpbds_req_if;
    import gpbds_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gpbds_rsp_if;
    import gpbds_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/gpbds_upd.sv
// Modify step of the shadow read-modify-write: applies one request to a port entry.
// Depends on gpbds_pkg.
module gpbds_upd (
    input  gpbds_pkg::t_req   i_req,
    input  gpbds_pkg::t_entry i_entry,
    input  logic              i_known,
    output gpbds_pkg::t_upd   o_upd
);
    import gpbds_pkg::*;

    function automatic logic [2*MASK_W-1:0] derive_pair(input t_entry e);
        logic [MASK_W-1:0] ddr;
        logic [MASK_W-1:0] prt;
        ddr = e.dir | (e.bias_on & e.bias_hard);
        prt = (e.dir & e.outv) | e.bias_on;
        return {ddr, prt};
    endfunction

    t_entry              cur;
    t_entry              nxt;
    logic [MASK_W-1:0]   lm;
    logic [MASK_W-1:0]   vmask;
    logic [PEXT_W-1:0]   pext;
    logic                in_range;
    logic                cmp;
    logic                unsup;
    logic [2*MASK_W-1:0] pair;

    always_comb begin
        // An entry never written since reset reads as all zero.
        cur      = i_known ? i_entry : '0;
        pext     = PEXT_W'(i_req.port_index);
        // One extra bit so that the port count itself fits in the compare.
        in_range = ({1'b0, pext} < (PEXT_W+1)'(NUM_PORTS));
        lm       = ({1'b0, i_req.line} < 4'(LINES_PER_PORT)) ?
                   (MASK_W'(1) << i_req.line) : '0;
        vmask    = i_req.value_mask & LINE_FIELD_MASK;
        nxt      = cur;
        cmp      = 1'b1;
        unsup    = 1'b0;

        unique case (t_cmd'(i_req.cmd))
            CMD_LOAD: begin
                nxt.dir        = i_req.readback_ddr;
                nxt.outv       = i_req.readback_port;
                nxt.bias_on    = i_req.readback_port & ~i_req.readback_ddr;
                nxt.bias_hard  = '0;
                nxt.last_pair  = {i_req.readback_ddr, i_req.readback_port};
                nxt.last_valid = 1'b1;
                cmp            = 1'b0;
            end
            CMD_INPUT: nxt.dir = cur.dir & ~lm;
            CMD_OUTPUT: begin
                nxt.dir  = cur.dir | lm;
                nxt.outv = i_req.level ? (cur.outv | lm) : (cur.outv & ~lm);
            end
            CMD_SETVAL: nxt.outv = (cur.outv & ~vmask) | (i_req.value_bits & vmask);
            CMD_BIAS_OFF: nxt.bias_on = cur.bias_on & ~lm;
            CMD_HIGHZ: begin
                nxt.bias_on = cur.bias_on & ~lm;
                nxt.dir     = cur.dir & ~lm;
            end
            CMD_PULL_DEF: begin
                if (i_req.arg_nonzero) begin
                    cmp = 1'b0;
                end else begin
                    nxt.bias_on   = cur.bias_on | lm;
                    nxt.bias_hard = cur.bias_hard & ~lm;
                end
            end
            CMD_PULL_UP: begin
                nxt.bias_on   = cur.bias_on | lm;
                nxt.bias_hard = i_req.arg_nonzero ? (cur.bias_hard & ~lm) :
                                (cur.bias_hard | lm);
            end
            CMD_INVAL: begin
                nxt.last_valid = 1'b0;
                cmp            = 1'b0;
            end
            default: begin
                cmp   = 1'b0;
                unsup = 1'b1;
            end
        endcase

        pair = derive_pair(nxt);
        o_upd.rsp.write_strobe = 1'b0;
        if (cmp && (!nxt.last_valid || (nxt.last_pair != pair))) begin
            nxt.last_pair          = pair;
            nxt.last_valid         = 1'b1;
            o_upd.rsp.write_strobe = 1'b1;
        end

        o_upd.wdata              = nxt;
        o_upd.we                 = in_range && !unsup;
        o_upd.rsp.port_reg       = pair[MASK_W-1:0];
        o_upd.rsp.ddr_reg        = pair[2*MASK_W-1:MASK_W];
        o_upd.rsp.direction_bits = nxt.dir;
        o_upd.rsp.status         = unsup ? ST_UNSUPPORTED : ST_OK;

        if (!in_range) begin
            o_upd.rsp        = '0;
            o_upd.rsp.status = ST_UNSUPPORTED;
        end
    end

endmodule

// File: rtl/core/gpio_port_bias_direction_shadow_core.sv
// GPIO port shadow core: per-port direction/value/bias masks in one memory.
// The port entry is read at acceptance; in S_CALC the update is written back and
// the response is registered once the output register is free.
// A new request is taken only after the write-back, so requests never overlap;
// the write-back waits while the output register holds a response.
// Reset is synchronous, active low; per-port valid flags make all entries read as zero.
module gpio_port_bias_direction_shadow_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gpbds_req_if.sink          i_req,
    gpbds_rsp_if.source        o_rsp
);
    import gpbds_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    t_entry             r_mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_known;
    logic               r_out_valid;
    logic               n_out_valid;
    t_rsp               r_out;
    t_upd               upd;
    logic               accept;
    logic               commit;
    logic [PORT_AW-1:0] in_addr;
    logic [PORT_AW-1:0] wr_addr;
    logic [PEXT_W-1:0]  in_pext;
    logic [PEXT_W-1:0]  wr_pext;

    assign in_pext = PEXT_W'(i_req.payload.port_index);
    assign wr_pext = PEXT_W'(r_req.port_index);
    assign in_addr = in_pext[PORT_AW-1:0];
    assign wr_addr = wr_pext[PORT_AW-1:0];

    gpbds_upd u_upd (
        .i_req   (r_req),
        .i_entry (r_rd_data),
        .i_known (r_rd_known),
        .o_upd   (upd)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        accept      = 1'b0;
        commit      = 1'b0;
        i_req.ready = 1'b0;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    accept  = 1'b1;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    commit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit && upd.we) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Shadow memory: read at acceptance, written back at commit. The two never
    // fall in the same cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req.payload;
            r_rd_data  <= r_mem[in_addr];
            r_rd_known <= r_vld[in_addr];
        end
        if (commit && upd.we) begin
            r_mem[wr_addr] <= upd.wdata;
        end
        if (commit) begin
            r_out <= upd.rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

// File: rtl/core/gpbds_chk.sv
// Port-level checker for the GPIO port shadow core, bound to the top level.
// Depends on gpbds_pkg and the assertion macro header.
`include "gpio_port_bias_direction_shadow_core_macros.svh"

module gpbds_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_strobe,
    input logic i_out_status
);
    import gpbds_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready && i_rst_n;

    // An unsupported request never asks for a device write.
    `GPBDS_ASSERT_SAME(a_unsup_no_strobe, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_UNSUPPORTED), !i_out_strobe, "strobe raised on an unsupported request")

    // The block works on one request at a time.
    `GPBDS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_acc, !i_in_ready, "request accepted while another is in work")

    // A fresh response must follow a request that was taken, after its read and commit steps.
    `GPBDS_ASSERT_SAME(a_rsp_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(in_acc, 2), "response without a matching request")

    `GPBDS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_strobe), "stalled response dropped or changed")

endmodule

bind gpio_port_bias_direction_shadow_core gpbds_chk u_gpbds_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_strobe (o_rsp.payload.write_strobe),
    .i_out_status (o_rsp.payload.status)
);

// File: test/tb_gpio_port_bias_direction_shadow_core.sv
// Testbench for the GPIO port shadow core: directed and random commands, with
// a predictor of the per-port masks checking every response field by field.
// Depends on gpbds_pkg, gpbds_if and the core itself.
module tb_gpio_port_bias_direction_shadow_core;
    import gpbds_pkg::*;

    typedef struct packed {
        logic drain;
        t_req req;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpbds_req_if cmd_ch();
    gpbds_rsp_if res_ch();

    gpio_port_bias_direction_shadow_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmd_ch),
        .o_rsp   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the per-port state.
    logic [MASK_W-1:0]   sh_dir       [NUM_PORTS] = '{default: '0};
    logic [MASK_W-1:0]   sh_out       [NUM_PORTS] = '{default: '0};
    logic [MASK_W-1:0]   sh_bias_on   [NUM_PORTS] = '{default: '0};
    logic [MASK_W-1:0]   sh_bias_hard [NUM_PORTS] = '{default: '0};
    logic [2*MASK_W-1:0] sh_last_pair [NUM_PORTS] = '{default: '0};
    logic                sh_last_ok   [NUM_PORTS] = '{default: 1'b0};

    t_item pend_q[$];
    t_rsp  want_q[$];

    int  err_cnt    = 0;
    int  acc_cnt    = 0;
    int  res_cnt    = 0;
    int  strobe_cnt = 0;
    bit  cmd_seen [16];
    bit  cmd_taken  = 1'b0;
    bit  res_taken  = 1'b0;
    bit  drv_busy   = 1'b0;
    int  drv_gap    = 0;
    int  rx_wait    = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    logic  nxt_valid;
    t_item nxt_item;

    // Every third block of 250 requests runs with no idling on either side.
    function automatic bit idle_on();
        return ((acc_cnt / 250) % 3) != 2;
    endfunction

    function automatic t_rsp shadow_apply(t_req r);
        t_rsp        rsp;
        logic [MASK_W-1:0] lm;
        logic [MASK_W-1:0] vm;
        logic [MASK_W-1:0] ddr;
        logic [MASK_W-1:0] prt;
        bit          may_write;
        int          p;
        rsp = '0;
        may_write = 1'b1;
        p = r.port_index;
        if (p >= NUM_PORTS) begin
            rsp.status = ST_UNSUPPORTED;
            return rsp;
        end
        lm = (r.line < LINES_PER_PORT) ? (MASK_W'(1) << r.line) : '0;
        case (r.cmd)
            CMD_LOAD: begin
                sh_dir[p]       = r.readback_ddr;
                sh_out[p]       = r.readback_port;
                sh_bias_on[p]   = r.readback_port & ~r.readback_ddr;
                sh_bias_hard[p] = '0;
                sh_last_pair[p] = {r.readback_ddr, r.readback_port};
                sh_last_ok[p]   = 1'b1;
                may_write = 1'b0;
            end
            CMD_INPUT: sh_dir[p] &= ~lm;
            CMD_OUTPUT: begin
                sh_dir[p] |= lm;
                sh_out[p] = r.level ? (sh_out[p] | lm) : (sh_out[p] & ~lm);
            end
            CMD_SETVAL: begin
                vm = r.value_mask & LINE_FIELD_MASK;
                sh_out[p] = (sh_out[p] & ~vm) | (r.value_bits & vm);
            end
            CMD_BIAS_OFF: sh_bias_on[p] &= ~lm;
            CMD_HIGHZ: begin
                sh_bias_on[p] &= ~lm;
                sh_dir[p] &= ~lm;
            end
            CMD_PULL_DEF: begin
                // A nonzero argument leaves the port untouched.
                if (r.arg_nonzero) begin
                    may_write = 1'b0;
                end else begin
                    sh_bias_on[p] |= lm;
                    sh_bias_hard[p] &= ~lm;
                end
            end
            CMD_PULL_UP: begin
                sh_bias_on[p] |= lm;
                sh_bias_hard[p] = r.arg_nonzero ? (sh_bias_hard[p] & ~lm)
                                                : (sh_bias_hard[p] | lm);
            end
            CMD_INVAL: begin
                sh_last_ok[p] = 1'b0;
                may_write = 1'b0;
            end
            default: begin
                rsp.status = ST_UNSUPPORTED;
                may_write = 1'b0;
            end
        endcase
        ddr = sh_dir[p] | (sh_bias_on[p] & sh_bias_hard[p]);
        prt = (sh_dir[p] & sh_out[p]) | sh_bias_on[p];
        rsp.port_reg       = prt;
        rsp.ddr_reg        = ddr;
        rsp.direction_bits = sh_dir[p];
        if (may_write && (!sh_last_ok[p] || sh_last_pair[p] != {ddr, prt})) begin
            sh_last_pair[p] = {ddr, prt};
            sh_last_ok[p]   = 1'b1;
            rsp.write_strobe = 1'b1;
        end
        return rsp;
    endfunction

    task automatic check_field(input string fname, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            err_cnt++;
        end
    endtask

    task automatic push_cmd(input t_cmd cmd, input int port, input int line, input bit level,
                            input int vmask, input int vbits, input bit argnz,
                            input int rbp, input int rbd, input bit drain);
        t_item it;
        it.drain               = drain;
        it.req.cmd             = cmd;
        it.req.port_index      = PIDX_W'(port);
        it.req.line            = LINE_W'(line);
        it.req.level           = level;
        it.req.value_mask      = MASK_W'(vmask);
        it.req.value_bits      = MASK_W'(vbits);
        it.req.arg_nonzero     = argnz;
        it.req.readback_port   = MASK_W'(rbp);
        it.req.readback_ddr    = MASK_W'(rbd);
        pend_q.push_back(it);
    endtask

    // Monitor: both handshakes are sampled on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            want_q.push_back(shadow_apply(cmd_ch.payload));
            cmd_seen[cmd_ch.payload.cmd] = 1'b1;
            cmd_taken = 1'b1;
            acc_cnt++;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            res_taken = 1'b1;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %0h",
                         $time, res_ch.payload);
                err_cnt++;
            end else begin
                t_rsp w;
                w = want_q.pop_front();
                check_field("write_strobe", w.write_strobe, res_ch.payload.write_strobe);
                check_field("port_reg", w.port_reg, res_ch.payload.port_reg);
                check_field("ddr_reg", w.ddr_reg, res_ch.payload.ddr_reg);
                check_field("direction_bits", w.direction_bits,
                            res_ch.payload.direction_bits);
                check_field("status", w.status, res_ch.payload.status);
                res_cnt++;
                if (w.write_strobe) strobe_cnt++;
            end
        end
    end

    // Driver: presents requests on the falling edge, with a random gap after each outside the no-idle blocks.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            nxt_valid = cmd_ch.valid;
            if (cmd_taken) begin
                cmd_taken = 1'b0;
                nxt_valid = 1'b0;
                drv_busy  = 1'b0;
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pend_q.size() > 0 && !(pend_q[0].drain && want_q.size() != 0)) begin
                    nxt_item = pend_q.pop_front();
                    cmd_ch.payload <= nxt_item.req;
                    nxt_valid = 1'b1;
                    drv_busy  = 1'b1;
                    drv_gap   = idle_on() ? $urandom_range(0, 3) : 0;
                end
            end
            cmd_ch.valid <= nxt_valid;
        end
    end

    // Receiver: random stall after each response outside the no-idle blocks, plus one long
    // hold-off so the core backs up and stalls its request side.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_taken) begin
                res_taken = 1'b0;
                rx_wait = idle_on() ? $urandom_range(0, 3) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && acc_cnt >= 500) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            res_ch.ready <= (rx_wait == 0 && hold_left == 0);
        end
    end

    initial begin
        logic [63:0] rnd;
        t_item       it;
        t_item       prev;
        int          k;
        int          n_on;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;

        // Directed part: extremes, every command and the special cases.
        push_cmd(CMD_LOAD,     0, 0, 0, 8'h00, 8'h00, 0, 8'hFF, 8'h00, 0);
        push_cmd(CMD_LOAD,    15, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'hFF, 0);
        push_cmd(CMD_LOAD,     3, 0, 0, 8'h00, 8'h00, 0, 8'hA5, 8'h5A, 0);
        push_cmd(CMD_INPUT,    0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_INPUT,   15, 7, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_OUTPUT,   0, 7, 1, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_OUTPUT,  15, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        // Repeating a command leaves the pair unchanged, so no write follows.
        push_cmd(CMD_OUTPUT,  15, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_SETVAL,   1, 0, 0, 8'hFF, 8'hFF, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_SETVAL,   1, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_SETVAL,   1, 0, 0, 8'h55, 8'hAA, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_BIAS_OFF, 0, 3, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_HIGHZ,   15, 7, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_PULL_DEF, 2, 2, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_PULL_DEF, 2, 2, 0, 8'h00, 8'h00, 1, 8'h00, 8'h00, 0);
        push_cmd(CMD_PULL_UP,  2, 5, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_PULL_UP,  2, 5, 0, 8'h00, 8'h00, 1, 8'h00, 8'h00, 0);
        push_cmd(CMD_INVAL,    2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        // After invalidation the same pair must be written again.
        push_cmd(CMD_PULL_UP,  2, 5, 0, 8'h00, 8'h00, 1, 8'h00, 8'h00, 0);
        push_cmd(t_cmd'(9),    4, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(t_cmd'(15),   4, 7, 1, 8'hFF, 8'hFF, 1, 8'hFF, 8'hFF, 0);
        push_cmd(CMD_INPUT,    7, 4, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0);
        push_cmd(CMD_SETVAL,   3, 0, 0, 8'hFF, 8'h00, 0, 8'h00, 8'h00, 1);

        // Random part: mostly valid commands on a few ports so state builds up.
        prev = '0;
        for (int i = 0; i < 1927; i++) begin
            if (i > 0 && $urandom_range(0, 99) < 12) begin
                it = prev;
            end else begin
                rnd = {$urandom, $urandom};
                it.req = rnd[$bits(t_req)-1:0];
                k = $urandom_range(0, 99);
                if (k < 4)
                    it.req.cmd = CMD_W'($urandom_range(CMD_INVAL + 1, (1 << CMD_W) - 1));
                else if (k < 12)
                    it.req.cmd = CMD_LOAD;
                else if (k < 18)
                    it.req.cmd = CMD_INVAL;
                else
                    it.req.cmd = CMD_W'($urandom_range(CMD_INPUT, CMD_PULL_UP));
                it.req.port_index = ($urandom_range(0, 99) < 70)
                                    ? PIDX_W'($urandom_range(0, 3))
                                    : PIDX_W'($urandom_range(0, 15));
            end
            it.drain = (i == 900) || ($urandom_range(0, 199) == 0);
            pend_q.push_back(it);
            prev = it;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || drv_busy) @(posedge i_clk);
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        n_on = 0;
        foreach (cmd_seen[c]) n_on += cmd_seen[c];
        $display("Run covered %0d requests and %0d responses, %0d with a register write,",
                 acc_cnt, res_cnt, strobe_cnt);
        $display("%0d of 16 command codes, a long output stall and drained pauses.", n_on);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
